// ===== rtl/core/btmx_pkg.sv =====
// Shared types, codes and sizes for the binary trie max-xor multiset unit.
package btmx_pkg;

	localparam int KEY_BITS    = 32;
	localparam int MAX_ENTRIES = 1024;
	localparam int VAL_W       = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] OP_INS  = 2'd0;
	localparam logic [1:0] OP_DEL  = 2'd1;
	localparam logic [1:0] OP_QRY  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [1:0] {
		MD_INS = 2'd0,
		MD_QRY = 2'd1,
		MD_CHK = 2'd2,
		MD_DEL = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [VAL_W-1:0] key_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] best_xor;
		logic [1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic [1:0][IDX_W-1:0] link;
		logic [1:0][CNT_W-1:0] cnt;
	} node_ent_t;

	localparam node_ent_t RST_ENT = '{
		link: '{IDX_W'(0), IDX_W'(0)},
		cnt:  '{CNT_W'(0), CNT_W'(1)}
	};

	typedef struct packed {
		logic                valid;
		mode_t               mode;
		logic [KEY_BITS-1:0] key;
		logic [IDX_W-1:0]    idx;
		logic                fresh;
		logic                alive;
		logic [KEY_BITS-1:0] best;
	} tok_t;

endpackage

// ===== rtl/core/btmx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module btmx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/btmx_cell.sv =====
// One trie level: node store, child allocator and per-level step of every operation.
module btmx_cell
	import btmx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  tok_t tin,
	output tok_t tout
);

	localparam int PTR_W = CNT_W;

	tok_t             tok_s1;
	logic             init_q;
	logic [PTR_W-1:0] sp_q;
	logic [PTR_W-1:0] hw_q;
	logic [PTR_W-1:0] sp_m1;
	logic [IDX_W-1:0] stk_rd;
	logic [IDX_W-1:0] stk_wd;
	logic             stk_we;
	logic [IDX_W-1:0] alloc_idx;
	node_ent_t        nd_rd;
	node_ent_t        nd_wr;
	node_ent_t        ent;
	logic             nd_we;
	logic             b;
	logic             want;
	logic             pop;
	logic [IDX_W-1:0] nxt;
	logic             nfresh;
	logic             alive_o;
	logic             qbit;

	btmx_ram #(.WIDTH($bits(node_ent_t)), .DEPTH(MAX_ENTRIES)) u_node_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (tok_s1.idx),
		.wdata (nd_wr),
		.raddr (tin.idx),
		.rdata (nd_rd)
	);

	btmx_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_free_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[IDX_W-1:0]),
		.wdata (stk_wd),
		.raddr (sp_m1[IDX_W-1:0]),
		.rdata (stk_rd)
	);

	assign sp_m1     = sp_q - PTR_W'(1);
	assign alloc_idx = (sp_q != '0) ? stk_rd : hw_q[IDX_W-1:0];
	assign b         = tok_s1.key[KEY_BITS-1];
	assign want      = ~b;

	always_comb begin
		if (tok_s1.fresh) begin
			ent = '0;
		end else if (init_q && (tok_s1.idx == '0)) begin
			ent = RST_ENT;
		end else begin
			ent = nd_rd;
		end
	end

	always_comb begin
		nd_wr   = ent;
		nd_we   = 1'b0;
		stk_we  = 1'b0;
		stk_wd  = ent.link[b];
		pop     = 1'b0;
		nxt     = ent.link[b];
		nfresh  = 1'b0;
		alive_o = tok_s1.alive;
		qbit    = 1'b0;
		unique case (tok_s1.mode)
			MD_INS: begin
				nd_we = tok_s1.valid;
				if (ent.cnt[b] == '0) begin
					pop         = tok_s1.valid;
					nd_wr.link[b] = alloc_idx;
					nd_wr.cnt[b]  = CNT_W'(1);
					nxt         = alloc_idx;
					nfresh      = 1'b1;
				end else begin
					nd_wr.cnt[b] = ent.cnt[b] + CNT_W'(1);
				end
			end
			MD_QRY: begin
				if (ent.cnt[want] != '0) begin
					nxt  = ent.link[want];
					qbit = tok_s1.alive;
				end else if (ent.cnt[b] == '0) begin
					alive_o = 1'b0;
				end
			end
			MD_CHK: begin
				if (ent.cnt[b] == '0) begin
					alive_o = 1'b0;
				end
			end
			MD_DEL: begin
				nd_we        = tok_s1.valid;
				nd_wr.cnt[b] = ent.cnt[b] - CNT_W'(1);
				if (ent.cnt[b] == CNT_W'(1)) begin
					stk_we = tok_s1.valid;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1.valid <= 1'b0;
		end else begin
			tok_s1 <= tin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b1;
			sp_q   <= '0;
			hw_q   <= PTR_W'(1);
		end else begin
			if (nd_we && (tok_s1.idx == '0)) begin
				init_q <= 1'b0;
			end
			if (pop) begin
				if (sp_q != '0) begin
					sp_q <= sp_m1;
				end else begin
					hw_q <= hw_q + PTR_W'(1);
				end
			end else if (stk_we) begin
				sp_q <= sp_q + PTR_W'(1);
			end
		end
	end

	always_comb begin
		tout.valid = tok_s1.valid;
		tout.mode  = tok_s1.mode;
		tout.key   = {tok_s1.key[KEY_BITS-2:0], 1'b0};
		tout.idx   = nxt;
		tout.fresh = nfresh;
		tout.alive = alive_o;
		tout.best  = {tok_s1.best[KEY_BITS-2:0], qbit};
	end

	a_hw_range: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= PTR_W'(MAX_ENTRIES))
		else $error("allocation mark beyond node store");

	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (sp_q == '0)) |-> (hw_q < PTR_W'(MAX_ENTRIES)))
		else $error("node allocated from an exhausted level");

endmodule

// ===== rtl/core/binary_trie_max_xor_multiset_unit.sv =====
// Top level: operation sequencer in front of a chain of per-level trie cells.
// An insert or query makes one pass through the cell chain; a remove of a present value makes two
// (a presence pass then an update pass); full, empty or unused-op cases skip the chain.
// One operation at a time; busy is high while an item is in the cell chain.
// The cell chain makes one node memory access per trie level per cycle.
// Reset leaves one copy of zero stored; no clearing pass, start is taken right away.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module binary_trie_max_xor_multiset_unit
	import btmx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] root_q;
	tok_t             tok_q;
	logic [KEY_BITS-1:0] key_q;
	logic             done_q;
	rsp_t             rsp_q;
	mode_t            launch_md;
	tok_t             chain [KEY_BITS+1];
	tok_t             last;

	assign chain[0] = tok_q;
	assign last     = chain[KEY_BITS];

	for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
		btmx_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (chain[i]),
			.tout   (chain[i+1])
		);
	end

	assign busy = (state_q == S_RUN);
	assign done = done_q;
	assign rsp  = rsp_q;

	always_comb begin
		unique case (req.op)
			OP_INS:  launch_md = MD_INS;
			OP_DEL:  launch_md = MD_CHK;
			OP_QRY:  launch_md = MD_QRY;
			default: launch_md = MD_QRY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_q      <= CNT_W'(1);
			tok_q.valid <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			tok_q.valid <= 1'b0;
			done_q      <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= KEY_BITS'(req.key_value);
						if ((req.op == OP_INS) && (root_q >= CNT_W'(MAX_ENTRIES))) begin
							done_q <= 1'b1;
							rsp_q  <= '{best_xor: '0, status: ST_FULL};
						end else if ((req.op == OP_QRY) && (root_q == '0)) begin
							done_q <= 1'b1;
							rsp_q  <= '{best_xor: '0, status: ST_EMPTY};
						end else if (req.op == OP_NONE) begin
							done_q <= 1'b1;
							rsp_q  <= '{best_xor: '0, status: ST_OK};
						end else begin
							tok_q.valid <= 1'b1;
							tok_q.mode  <= launch_md;
							tok_q.key   <= KEY_BITS'(req.key_value);
							tok_q.idx   <= '0;
							tok_q.fresh <= 1'b0;
							tok_q.alive <= 1'b1;
							tok_q.best  <= '0;
							state_q     <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (last.valid) begin
						unique case (last.mode)
							MD_INS: begin
								root_q  <= root_q + CNT_W'(1);
								done_q  <= 1'b1;
								rsp_q   <= '{best_xor: '0, status: ST_OK};
								state_q <= S_IDLE;
							end
							MD_QRY: begin
								done_q  <= 1'b1;
								rsp_q   <= '{best_xor: VAL_W'(last.best), status: ST_OK};
								state_q <= S_IDLE;
							end
							MD_CHK: begin
								if (last.alive) begin
									tok_q.valid <= 1'b1;
									tok_q.mode  <= MD_DEL;
									tok_q.key   <= key_q;
									tok_q.idx   <= '0;
									tok_q.fresh <= 1'b0;
									tok_q.alive <= 1'b1;
									tok_q.best  <= '0;
								end else begin
									done_q  <= 1'b1;
									rsp_q   <= '{best_xor: '0, status: ST_ABSENT};
									state_q <= S_IDLE;
								end
							end
							MD_DEL: begin
								root_q  <= root_q - CNT_W'(1);
								done_q  <= 1'b1;
								rsp_q   <= '{best_xor: '0, status: ST_OK};
								state_q <= S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while an operation is in flight");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		root_q <= CNT_W'(MAX_ENTRIES))
		else $error("stored value count beyond capacity");

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid |-> busy)
		else $error("item leaves the cell chain while idle");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.op == OP_INS) && (root_q >= CNT_W'(MAX_ENTRIES)))
		|=> (done && (rsp.status == ST_FULL)))
		else $error("insert into a full store not refused");

endmodule

// ===== sim/binary_trie_max_xor_multiset_unit_tb.sv =====
// Self-checking testbench for the binary trie max-xor multiset unit.
`timescale 1ns / 100ps

module binary_trie_max_xor_multiset_unit_tb
	import btmx_pkg::*;
();

	typedef struct {
		req_t req;
		bit   drain_first;
		bit   calm;
	} trie_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	trie_cmd_t         pending[$];
	rsp_t              rsp_due[$];
	logic [VAL_W-1:0]  stored_vals[$];
	logic [VAL_W-1:0]  gen_vals[$];
	bit                item_taken = 1'b0;
	bit                start_hold = 1'b0;
	int                err_cnt = 0;
	int                op_seen[4] = '{0, 0, 0, 0};
	int                status_seen[4] = '{0, 0, 0, 0};
	rsp_t              due_rsp;

	binary_trie_max_xor_multiset_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t trie_apply(req_t r);
		rsp_t             o;
		int               hit;
		logic [VAL_W-1:0] best;
		o = '0;
		hit = -1;
		best = '0;
		case (r.op)
			OP_INS: begin
				if (stored_vals.size() >= MAX_ENTRIES)
					o.status = ST_FULL;
				else
					stored_vals.push_back(r.key_value);
			end
			OP_DEL: begin
				for (int i = 0; i < stored_vals.size() && hit < 0; i++)
					if (stored_vals[i] == r.key_value)
						hit = i;
				if (hit < 0)
					o.status = ST_ABSENT;
				else
					stored_vals.delete(hit);
			end
			OP_QRY: begin
				if (stored_vals.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					foreach (stored_vals[i])
						if ((stored_vals[i] ^ r.key_value) > best)
							best = stored_vals[i] ^ r.key_value;
					o.best_xor = best;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 45 || gen_vals.size() == 0)
			return $urandom();
		if (sel < 75)
			return gen_vals[$urandom_range(gen_vals.size() - 1)] ^ (32'd1 << $urandom_range(31));
		if (sel < 90)
			return gen_vals[$urandom_range(gen_vals.size() - 1)] ^ ($urandom() & 32'h0000_00ff);
		return 32'($urandom_range(15)) << (4 * $urandom_range(7));
	endfunction

	function automatic logic [VAL_W-1:0] pick_present();
		if (gen_vals.size() == 0)
			return $urandom();
		return gen_vals[$urandom_range(gen_vals.size() - 1)];
	endfunction

	task automatic add_item(logic [1:0] op, logic [VAL_W-1:0] val, bit drain, bit calm);
		trie_cmd_t c;
		int        hit;
		c.req.op = op;
		c.req.key_value = val;
		c.drain_first = drain;
		c.calm = calm;
		hit = -1;
		pending.push_back(c);
		if (op == OP_INS && gen_vals.size() < MAX_ENTRIES) begin
			gen_vals.push_back(val);
		end else if (op == OP_DEL) begin
			for (int i = 0; i < gen_vals.size() && hit < 0; i++)
				if (gen_vals[i] == val)
					hit = i;
			if (hit >= 0)
				gen_vals.delete(hit);
		end
	endtask

	task automatic add_mixed(bit drain, bit calm);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35)
			add_item(OP_INS, pick_value(), drain, calm);
		else if (sel < 55)
			add_item(OP_DEL, pick_present(), drain, calm);
		else if (sel < 62)
			add_item(OP_DEL, pick_value(), drain, calm);
		else if (sel < 95)
			add_item(OP_QRY, $urandom_range(1) ? $urandom() : pick_value(), drain, calm);
		else
			add_item(OP_NONE, $urandom(), drain, calm);
	endtask

	// drive at the falling edge; hold start until the item is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_taken) begin
				item_taken = 1'b0;
				pending.delete(0);
				start_hold = 1'b0;
			end
			if (!start_hold && pending.size() != 0 &&
			    !(pending[0].drain_first && rsp_due.size() != 0) &&
			    (pending[0].calm || $urandom_range(99) >= 20))
				start_hold = 1'b1;
			start <= start_hold;
			if (start_hold)
				req <= pending[0].req;
		end
	end

	// check results, then record the item taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					$error("result strobe with no item outstanding");
					err_cnt++;
				end else begin
					due_rsp = rsp_due.pop_front();
					status_seen[rsp.status]++;
					if (rsp.best_xor !== due_rsp.best_xor) begin
						$error("best_xor: expected %h, got %h", due_rsp.best_xor, rsp.best_xor);
						err_cnt++;
					end
					if (rsp.status !== due_rsp.status) begin
						$error("status: expected %0d, got %0d", due_rsp.status, rsp.status);
						err_cnt++;
					end
				end
			end
			if (start && !busy) begin
				rsp_due.push_back(trie_apply(req));
				op_seen[req.op]++;
				item_taken = 1'b1;
			end
		end
	end

	initial begin
		int fill_cnt;
		stored_vals.push_back('0);
		gen_vals.push_back('0);

		add_item(OP_QRY, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_QRY, 32'hffff_ffff, 1'b0, 1'b0);
		add_item(OP_DEL, 32'h0000_0005, 1'b0, 1'b0);
		add_item(OP_DEL, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_QRY, 32'h1234_5678, 1'b0, 1'b0);
		add_item(OP_DEL, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_INS, 32'hffff_ffff, 1'b0, 1'b0);
		add_item(OP_INS, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_INS, 32'h8000_0000, 1'b0, 1'b0);
		add_item(OP_INS, 32'h7fff_ffff, 1'b0, 1'b0);
		add_item(OP_INS, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_QRY, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_QRY, 32'hffff_ffff, 1'b0, 1'b0);
		add_item(OP_QRY, 32'h8000_0000, 1'b0, 1'b0);
		add_item(OP_QRY, 32'h5555_5555, 1'b0, 1'b0);
		add_item(OP_QRY, 32'haaaa_aaaa, 1'b0, 1'b0);
		add_item(OP_DEL, 32'hffff_ffff, 1'b0, 1'b0);
		add_item(OP_QRY, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_NONE, 32'hffff_ffff, 1'b0, 1'b0);
		add_item(OP_NONE, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_DEL, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_DEL, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_QRY, 32'h0000_0000, 1'b1, 1'b0);

		for (int i = 0; i < 24; i++)
			add_mixed(i == 12, 1'b0);

		// grow the store to its limit; the first stretch runs with no gaps
		fill_cnt = 0;
		while (gen_vals.size() < MAX_ENTRIES) begin
			if ($urandom_range(99) < 2)
				add_item(OP_QRY, $urandom(), 1'b0, fill_cnt < 250);
			else
				add_item(OP_INS, ($urandom_range(9) == 0) ? pick_present() : pick_value(),
					1'b0, fill_cnt < 250);
			fill_cnt++;
		end
		add_item(OP_INS, $urandom(), 1'b1, 1'b0);
		add_item(OP_INS, 32'h0000_0000, 1'b0, 1'b0);
		add_item(OP_INS, 32'hffff_ffff, 1'b0, 1'b0);
		add_item(OP_QRY, $urandom(), 1'b0, 1'b0);
		add_item(OP_NONE, $urandom(), 1'b0, 1'b0);
		add_item(OP_DEL, $urandom(), 1'b0, 1'b0);
		add_item(OP_DEL, pick_present(), 1'b0, 1'b0);
		add_item(OP_INS, pick_value(), 1'b0, 1'b0);
		add_item(OP_INS, pick_value(), 1'b0, 1'b0);
		add_item(OP_QRY, $urandom(), 1'b0, 1'b0);

		for (int i = 0; i < 30; i++) begin
			case ($urandom_range(19))
				0, 1, 2:
					add_item(OP_INS, pick_value(), 1'b0, 1'b0);
				3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
					add_item(OP_DEL, pick_present(), i == 15, 1'b0);
				default:
					add_item(OP_QRY, $urandom(), 1'b0, 1'b0);
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending.size() != 0 || rsp_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("Covered %0d items: %0d insert, %0d remove, %0d query, %0d unused op",
			op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
			op_seen[OP_INS], op_seen[OP_DEL], op_seen[OP_QRY], op_seen[OP_NONE]);
		$display("Statuses returned: %0d ok, %0d absent, %0d empty store, %0d pool full",
			status_seen[ST_OK], status_seen[ST_ABSENT], status_seen[ST_EMPTY],
			status_seen[ST_FULL]);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/btmx_pkg.sv
rtl/core/btmx_ram.sv
rtl/core/btmx_cell.sv
rtl/core/binary_trie_max_xor_multiset_unit.sv
sim/binary_trie_max_xor_multiset_unit_tb.sv
